// ----- rtl/core/vts_pkg.sv -----
// shared constants for the volume trilinear sampler
// no dependencies; imported by every module of the block
package vts_pkg;

    // parameter defaults
    localparam int AXIS_MAX_DEF   = 64;
    localparam int VALUE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    // fixed field widths
    localparam int COORD_W     = 24;
    localparam int IDX_W       = 6;
    localparam int IN_VALUE_W  = 16;
    localparam int OUT_W       = 16;
    localparam int SIZE_W      = 7;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Z = 2'd2;

    // size register reset value
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

endpackage

// ----- rtl/core/vts_axis_split.sv -----
// one axis of a sample point: clamp to the grid and split into cell and fraction
// depends on vts_pkg
module vts_axis_split
    import vts_pkg::*;
#(
    parameter int AXIS_MAX  = AXIS_MAX_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic signed [COORD_W-1:0]       coord,
    input  logic        [SIZE_W-1:0]        size_cfg,
    output logic        [$clog2(AXIS_MAX)-1:0] idx_lo,
    output logic        [$clog2(AXIS_MAX)-1:0] idx_hi,
    output logic        [FRAC_BITS-1:0]     frac,
    output logic                            clamped
);

    localparam int AW = $clog2(AXIS_MAX);
    localparam int CW = (AW + FRAC_BITS + 1 > COORD_W + 1) ? AW + FRAC_BITS + 1 : COORD_W + 1;

    logic        [AW-1:0] dim_m1;
    logic signed [CW-1:0] coord_ext;
    logic signed [CW-1:0] upper;
    logic signed [CW-1:0] coord_clamped;
    logic                 below;
    logic                 above;

    // effective size saturated to [2, AXIS_MAX], minus one
    always_comb
    begin
        if (32'(size_cfg) < 2)
        begin
            dim_m1 = AW'(1);
        end
        else if (32'(size_cfg) > AXIS_MAX)
        begin
            dim_m1 = AW'(AXIS_MAX - 1);
        end
        else
        begin
            dim_m1 = AW'(size_cfg - 7'd1);
        end
    end

    // clamp to [0, (dim-1) << frac]
    assign coord_ext = CW'(coord);
    assign upper     = signed'(CW'(dim_m1) << FRAC_BITS);
    assign below     = coord[COORD_W-1];
    assign above     = coord_ext > upper;
    assign clamped   = below | above;

    always_comb
    begin
        if (below)
        begin
            coord_clamped = '0;
        end
        else if (above)
        begin
            coord_clamped = upper;
        end
        else
        begin
            coord_clamped = coord_ext;
        end
    end

    // cell, fraction and upper neighbour held at the edge
    assign idx_lo = coord_clamped[FRAC_BITS +: AW];
    assign frac   = coord_clamped[FRAC_BITS-1:0];
    assign idx_hi = (idx_lo == dim_m1) ? idx_lo : idx_lo + AW'(1);

endmodule

// ----- rtl/core/vts_lerp.sv -----
// two-stage linear blend a + f*(b-a), rounded to nearest with ties upward
// depends on vts_pkg
module vts_lerp
    import vts_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic signed [VALUE_BITS-1:0] a,
    input  logic signed [VALUE_BITS-1:0] b,
    input  logic        [FRAC_BITS-1:0]  f,
    output logic signed [VALUE_BITS-1:0] lerp_out
);

    localparam int PW = VALUE_BITS + FRAC_BITS + 2;
    localparam int TW = VALUE_BITS + FRAC_BITS + 3;

    logic signed [VALUE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]    f_signed;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         prod_reg;
    logic signed [VALUE_BITS-1:0] a_reg;
    logic signed [TW-1:0]         total;

    // first stage: difference times weight
    assign diff     = (VALUE_BITS+1)'(b) - (VALUE_BITS+1)'(a);
    assign f_signed = signed'({1'b0, f});
    assign prod     = PW'(diff) * PW'(f_signed);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        a_reg    <= a;
    end

    // second stage: add scaled base and half, floor shift
    assign total = (TW'(a_reg) <<< FRAC_BITS) + TW'(prod_reg)
                   + (TW'(1) <<< (FRAC_BITS - 1));
    assign lerp_out = total[FRAC_BITS +: VALUE_BITS];

endmodule

// ----- rtl/core/volume_trilinear_sampler_top.sv -----
// result: a sample item raises done with its result as busy falls after the last step
// throughput: no item is accepted while a sample is busy (eight corner reads on the
// single voxel memory port, with the shared two-stage blend unit); write items one
// per cycle while idle; reset: control registers clear and size registers go to 64
// at once; the voxel memory is not cleared and is undefined until written; the
// receiver cannot stall done; depends on vts_pkg, vts_axis_split, vts_lerp
module volume_trilinear_sampler_top
    import vts_pkg::*;
#(
    parameter int AXIS_MAX   = AXIS_MAX_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write,
    input  logic        [CFG_INDEX_W-1:0] cfg_index,
    input  logic        [SIZE_W-1:0]      cfg_data,
    // command
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic        [IDX_W-1:0]       voxel_x,
    input  logic        [IDX_W-1:0]       voxel_y,
    input  logic        [IDX_W-1:0]       voxel_z,
    input  logic signed [IN_VALUE_W-1:0]  voxel_value,
    input  logic signed [COORD_W-1:0]     coord_x,
    input  logic signed [COORD_W-1:0]     coord_y,
    input  logic signed [COORD_W-1:0]     coord_z,
    // result
    output logic                          done,
    output logic signed [OUT_W-1:0]       sample_value,
    output logic                          was_clamped
);

    localparam int AW    = $clog2(AXIS_MAX);
    localparam int DEPTH = AXIS_MAX * AXIS_MAX * AXIS_MAX;
    localparam int ADW   = $clog2(DEPTH);
    localparam int OW    = (VALUE_BITS > OUT_W) ? VALUE_BITS : OUT_W;
    localparam logic [ADW-1:0] STRIDE_Y = ADW'(AXIS_MAX);
    localparam logic [ADW-1:0] STRIDE_Z = ADW'(AXIS_MAX * AXIS_MAX);

    // sequencer steps
    localparam logic [3:0] STEP_FIRST     = 4'd0;
    localparam logic [3:0] STEP_READ_LAST = 4'd7;
    localparam logic [3:0] STEP_Y0        = 4'd7;
    localparam logic [3:0] STEP_Y1        = 4'd10;
    localparam logic [3:0] STEP_Z         = 4'd12;
    localparam logic [3:0] STEP_DONE      = 4'd13;

    // configuration registers
    logic [SIZE_W-1:0] size_x_reg;
    logic [SIZE_W-1:0] size_y_reg;
    logic [SIZE_W-1:0] size_z_reg;

    // control
    logic       busy_reg;
    logic       busy_next;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    logic       done_reg;
    logic       done_next;
    logic       accept;
    logic       sample_accept;

    // axis split
    logic [AW-1:0]        sx_lo, sx_hi, sy_lo, sy_hi, sz_lo, sz_hi;
    logic [FRAC_BITS-1:0] sx_f, sy_f, sz_f;
    logic                 sx_cl, sy_cl, sz_cl;

    logic [AW-1:0]        x0_reg, x1_reg, y0_reg, y1_reg, z0_reg, z1_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg, fz_reg;
    logic                 clamped_reg;

    // memory
    logic signed [VALUE_BITS-1:0] voxel_mem [DEPTH];
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic signed [VALUE_BITS-1:0] wr_value;
    logic                         mem_we;
    logic                         mem_re;
    logic                         wr_in_range;
    logic [ADW-1:0]               wr_addr;
    logic [ADW-1:0]               rd_addr;
    logic [ADW-1:0]               mem_addr;
    logic [AW-1:0]                rd_x, rd_y, rd_z;

    // blend datapath
    logic signed [VALUE_BITS-1:0] even_reg;
    logic signed [VALUE_BITS-1:0] vx0_reg, vx1_reg, vx2_reg, vx3_reg;
    logic signed [VALUE_BITS-1:0] vy0_reg, vy1_reg;
    logic signed [VALUE_BITS-1:0] lerp_a, lerp_b, lerp_y;
    logic        [FRAC_BITS-1:0]  lerp_f;
    logic signed [OW-1:0]         result_wide;
    logic signed [OUT_W-1:0]      sample_value_reg;
    logic                         was_clamped_reg;

    assign accept        = start & ~busy_reg;
    assign sample_accept = accept & (operation == OP_SAMPLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_data;
                REG_SIZE_Y: size_y_reg <= cfg_data;
                REG_SIZE_Z: size_z_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // axis clamp and split
    vts_axis_split #(.AXIS_MAX(AXIS_MAX), .FRAC_BITS(FRAC_BITS)) u_split_x
    (
        .coord(coord_x), .size_cfg(size_x_reg),
        .idx_lo(sx_lo), .idx_hi(sx_hi), .frac(sx_f), .clamped(sx_cl)
    );

    vts_axis_split #(.AXIS_MAX(AXIS_MAX), .FRAC_BITS(FRAC_BITS)) u_split_y
    (
        .coord(coord_y), .size_cfg(size_y_reg),
        .idx_lo(sy_lo), .idx_hi(sy_hi), .frac(sy_f), .clamped(sy_cl)
    );

    vts_axis_split #(.AXIS_MAX(AXIS_MAX), .FRAC_BITS(FRAC_BITS)) u_split_z
    (
        .coord(coord_z), .size_cfg(size_z_reg),
        .idx_lo(sz_lo), .idx_hi(sz_hi), .frac(sz_f), .clamped(sz_cl)
    );

    // hold the split point for the whole sample
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            x0_reg      <= sx_lo;
            x1_reg      <= sx_hi;
            y0_reg      <= sy_lo;
            y1_reg      <= sy_hi;
            z0_reg      <= sz_lo;
            z1_reg      <= sz_hi;
            fx_reg      <= sx_f;
            fy_reg      <= sy_f;
            fz_reg      <= sz_f;
            clamped_reg <= sx_cl | sy_cl | sz_cl;
        end
    end

    // sequencer next state
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (!busy_reg)
        begin
            if (sample_accept)
            begin
                busy_next = 1'b1;
                cnt_next  = STEP_FIRST;
            end
        end
        else if (cnt_reg == STEP_DONE)
        begin
            busy_next = 1'b0;
            cnt_next  = STEP_FIRST;
        end
        else
        begin
            cnt_next = cnt_reg + 4'd1;
        end
    end

    assign done_next = busy_reg & (cnt_reg == STEP_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= STEP_FIRST;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // write value saturated to the stored width
    generate
        if (VALUE_BITS >= IN_VALUE_W)
        begin : g_wr_wide
            assign wr_value = VALUE_BITS'(voxel_value);
        end
        else
        begin : g_wr_sat
            localparam logic signed [IN_VALUE_W-1:0] VHI = IN_VALUE_W'(2**(VALUE_BITS-1) - 1);
            localparam logic signed [IN_VALUE_W-1:0] VLO = -VHI - IN_VALUE_W'(1);
            always_comb
            begin
                if (voxel_value > VHI)
                begin
                    wr_value = VHI[VALUE_BITS-1:0];
                end
                else if (voxel_value < VLO)
                begin
                    wr_value = VLO[VALUE_BITS-1:0];
                end
                else
                begin
                    wr_value = voxel_value[VALUE_BITS-1:0];
                end
            end
        end
    endgenerate

    // write address; indexes beyond the store are dropped
    assign wr_in_range = (32'(voxel_x) < AXIS_MAX) && (32'(voxel_y) < AXIS_MAX)
                         && (32'(voxel_z) < AXIS_MAX);
    assign wr_addr = ADW'(voxel_x) + STRIDE_Y * ADW'(voxel_y) + STRIDE_Z * ADW'(voxel_z);
    assign mem_we  = accept & (operation == OP_WRITE) & wr_in_range;

    // corner address: bit 0 picks x, bit 1 picks y, bit 2 picks z
    assign rd_x    = cnt_reg[0] ? x1_reg : x0_reg;
    assign rd_y    = cnt_reg[1] ? y1_reg : y0_reg;
    assign rd_z    = cnt_reg[2] ? z1_reg : z0_reg;
    assign rd_addr = ADW'(rd_x) + STRIDE_Y * ADW'(rd_y) + STRIDE_Z * ADW'(rd_z);
    assign mem_re  = busy_reg & (cnt_reg <= STEP_READ_LAST);

    // single port: reads only while busy, writes only while idle
    assign mem_addr = busy_reg ? rd_addr : wr_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            voxel_mem[mem_addr] <= wr_value;
        end
        if (mem_re)
        begin
            rd_data_reg <= voxel_mem[mem_addr];
        end
    end

    // blend unit input selection
    always_comb
    begin
        case (cnt_reg)
            STEP_Y0:
            begin
                lerp_a = vx0_reg;
                lerp_b = vx1_reg;
                lerp_f = fy_reg;
            end
            STEP_Y1:
            begin
                lerp_a = vx2_reg;
                lerp_b = vx3_reg;
                lerp_f = fy_reg;
            end
            STEP_Z:
            begin
                lerp_a = vy0_reg;
                lerp_b = vy1_reg;
                lerp_f = fz_reg;
            end
            default:
            begin
                lerp_a = even_reg;
                lerp_b = rd_data_reg;
                lerp_f = fx_reg;
            end
        endcase
    end

    vts_lerp #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_lerp
    (
        .clk(clk), .a(lerp_a), .b(lerp_b), .f(lerp_f), .lerp_out(lerp_y)
    );

    // even corner held for its x pair; blend results captured in the cycle after issue
    always_ff @(posedge clk)
    begin
        if (busy_reg && (cnt_reg inside {4'd1, 4'd3, 4'd5, 4'd7}))
        begin
            even_reg <= rd_data_reg;
        end
        if (busy_reg)
        begin
            case (cnt_reg)
                4'd3:    vx0_reg <= lerp_y;
                4'd5:    vx1_reg <= lerp_y;
                4'd7:    vx2_reg <= lerp_y;
                4'd8:    vy0_reg <= lerp_y;
                4'd9:    vx3_reg <= lerp_y;
                4'd11:   vy1_reg <= lerp_y;
                default: ;
            endcase
        end
    end

    // result register
    assign result_wide = OW'(lerp_y);

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            sample_value_reg <= result_wide[OUT_W-1:0];
            was_clamped_reg  <= clamped_reg;
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign sample_value = sample_value_reg;
    assign was_clamped  = was_clamped_reg;

`ifndef SYNTHESIS
    // a sample item accepted while idle is followed by its done strobe
    a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_SAMPLE) |-> ##15 done)
        else $error("sample result missing at expected cycle");

    // the strobe comes only as the sequencer leaves its last step
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside end of sample");

    // step counter stays within the schedule
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= STEP_DONE))
        else $error("step counter out of range");
`endif

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for volume_trilinear_sampler_top: voxel writes and trilinear samples
// holds its own voxel shadow and blend predictor; depends on vts_pkg and the rtl top level
module testbench;
    import vts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT          = 1 << FRAC_BITS_DEF;
    localparam int ITEM_TARGET   = 1250;
    localparam int OPENING_ROWS  = 19;
    localparam int FIXED_SIZES   = 7;
    localparam int SIZE_SETTINGS = 10;
    localparam int PHASE_ITEMS   = (ITEM_TARGET - OPENING_ROWS) / SIZE_SETTINGS;
    localparam int SETTLE_CYCLES = 20;
    localparam int PRINT_LIMIT   = 40;

    localparam logic [CFG_INDEX_W-1:0] SIZE_REGS [3] = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};

    // one command item as driven on the ports, plus an optional known answer
    typedef struct packed {
        logic                     op;
        logic [2:0][IDX_W-1:0]    idx;
        logic [IN_VALUE_W-1:0]    value;
        logic [2:0][COORD_W-1:0]  coord;
        logic                     known;
        logic [OUT_W-1:0]         known_value;
        logic                     known_clamped;
    } grid_cmd_t;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             clamped;
    } sample_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic        [CFG_INDEX_W-1:0] cfg_index = '0;
    logic        [SIZE_W-1:0]      cfg_data = '0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          operation = OP_WRITE;
    logic        [IDX_W-1:0]       voxel_x = '0;
    logic        [IDX_W-1:0]       voxel_y = '0;
    logic        [IDX_W-1:0]       voxel_z = '0;
    logic signed [IN_VALUE_W-1:0]  voxel_value = '0;
    logic signed [COORD_W-1:0]     coord_x = '0;
    logic signed [COORD_W-1:0]     coord_y = '0;
    logic signed [COORD_W-1:0]     coord_z = '0;
    logic                          done;
    logic signed [OUT_W-1:0]       sample_value;
    logic                          was_clamped;

    // shadow of the voxel memory; an entry exists only once written
    logic signed [IN_VALUE_W-1:0] voxel_shadow [int];
    int             grid_dim [3] = '{AXIS_MAX_DEF, AXIS_MAX_DEF, AXIS_MAX_DEF};
    int             focus_cell [3];
    sample_result_t pending_samples [$];
    bit             steady_run = 1'b0;

    int fixed_sizes [FIXED_SIZES][3] = '{'{2, 2, 2}, '{64, 64, 64}, '{0, 1, 127},
                                        '{3, 5, 7}, '{2, 64, 2}, '{65, 33, 1}, '{64, 2, 64}};

    int items_sent;
    int writes_sent;
    int samples_sent;
    int clamped_sent;
    int results_checked;
    int size_settings_run;
    int error_count;

    volume_trilinear_sampler_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .voxel_x      (voxel_x),
        .voxel_y      (voxel_y),
        .voxel_z      (voxel_z),
        .voxel_value  (voxel_value),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .done         (done),
        .sample_value (sample_value),
        .was_clamped  (was_clamped)
    );

    // 12 ns clock
    always
    begin
        #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int voxel_key(input int x, input int y, input int z);
        return x + AXIS_MAX_DEF * (y + AXIS_MAX_DEF * z);
    endfunction

    function automatic longint stored_voxel(input int x, input int y, input int z);
        int key;
        key = voxel_key(x, y, z);
        if (voxel_shadow.exists(key))
            return longint'(voxel_shadow[key]);
        return 0;
    endfunction

    // a + f*(b-a)/UNIT, rounded to nearest with ties upward
    function automatic longint blend(input longint a, input longint b, input longint f);
        longint t;
        t = a * UNIT + f * (b - a) + UNIT / 2;
        return t >>> FRAC_BITS_DEF;
    endfunction

    // clamp one coordinate to [0, (dim-1)*UNIT] and split into cell, neighbor and fraction
    function automatic void split_axis(input logic [COORD_W-1:0] raw, input int dim,
                                       output int lo, output int hi, output longint frac,
                                       output bit clamped);
        longint pos;
        longint top;
        pos = longint'($signed(raw));
        top = longint'(dim - 1) * UNIT;
        clamped = 1'b0;
        if (pos < 0)
        begin
            pos = 0;
            clamped = 1'b1;
        end
        if (pos > top)
        begin
            pos = top;
            clamped = 1'b1;
        end
        lo = int'(pos / UNIT);
        frac = pos % UNIT;
        hi = (lo + 1 > dim - 1) ? dim - 1 : lo + 1;
    endfunction

    function automatic int pick_value();
        case ($urandom_range(0, 9))
            0: return 32767;
            1: return -32768;
            2: return $urandom_range(0, 1) ? 0 : -1;
            default: return int'($urandom);
        endcase
    endfunction

    // write item; coordinate fields carry noise
    function automatic grid_cmd_t voxel_write(input int x, input int y, input int z,
                                              input int value);
        grid_cmd_t c;
        c = '0;
        c.op = OP_WRITE;
        c.idx[0] = x[IDX_W-1:0];
        c.idx[1] = y[IDX_W-1:0];
        c.idx[2] = z[IDX_W-1:0];
        c.value = value[IN_VALUE_W-1:0];
        for (int a = 0; a < 3; a++)
            c.coord[a] = COORD_W'($urandom);
        return c;
    endfunction

    // sample item; voxel fields carry noise
    function automatic grid_cmd_t sample_point(input int cx, input int cy, input int cz,
                                               input bit known, input int value,
                                               input bit clamped);
        grid_cmd_t c;
        c = '0;
        c.op = OP_SAMPLE;
        for (int a = 0; a < 3; a++)
            c.idx[a] = IDX_W'($urandom);
        c.value = IN_VALUE_W'($urandom);
        c.coord[0] = cx[COORD_W-1:0];
        c.coord[1] = cy[COORD_W-1:0];
        c.coord[2] = cz[COORD_W-1:0];
        c.known = known;
        c.known_value = value[OUT_W-1:0];
        c.known_clamped = clamped;
        return c;
    endfunction

    // drive one item after a random gap, wait for acceptance, then predict
    task automatic issue_item(input grid_cmd_t c);
        int             gap;
        int             roll;
        int             lo [3];
        int             hi [3];
        longint         fr [3];
        bit             cl [3];
        longint         row [4];
        longint         plane [2];
        sample_result_t want;
        if (steady_run)
            gap = 0;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                gap = 0;
            else if (roll < 85)
                gap = $urandom_range(1, 3);
            else if (roll < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(13, 40);
        end

        // idle cycles with noise on the item fields
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
            begin
                operation   <= 1'($urandom);
                voxel_x     <= IDX_W'($urandom);
                voxel_y     <= IDX_W'($urandom);
                voxel_z     <= IDX_W'($urandom);
                voxel_value <= IN_VALUE_W'($urandom);
                coord_x     <= COORD_W'($urandom);
                coord_y     <= COORD_W'($urandom);
                coord_z     <= COORD_W'($urandom);
                @(posedge clk);
            end
        end

        start       <= 1'b1;
        operation   <= c.op;
        voxel_x     <= c.idx[0];
        voxel_y     <= c.idx[1];
        voxel_z     <= c.idx[2];
        voxel_value <= c.value;
        coord_x     <= c.coord[0];
        coord_y     <= c.coord[1];
        coord_z     <= c.coord[2];
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);

        // item accepted at this edge
        items_sent++;
        if (c.op == OP_WRITE)
        begin
            voxel_shadow[voxel_key(int'(c.idx[0]), int'(c.idx[1]), int'(c.idx[2]))] =
                $signed(c.value);
            writes_sent++;
        end
        else
        begin
            for (int a = 0; a < 3; a++)
                split_axis(c.coord[a], grid_dim[a], lo[a], hi[a], fr[a], cl[a]);
            // four lerps along x, two along y, one along z
            row[0] = blend(stored_voxel(lo[0], lo[1], lo[2]), stored_voxel(hi[0], lo[1], lo[2]),
                           fr[0]);
            row[1] = blend(stored_voxel(lo[0], hi[1], lo[2]), stored_voxel(hi[0], hi[1], lo[2]),
                           fr[0]);
            row[2] = blend(stored_voxel(lo[0], lo[1], hi[2]), stored_voxel(hi[0], lo[1], hi[2]),
                           fr[0]);
            row[3] = blend(stored_voxel(lo[0], hi[1], hi[2]), stored_voxel(hi[0], hi[1], hi[2]),
                           fr[0]);
            plane[0] = blend(row[0], row[1], fr[1]);
            plane[1] = blend(row[2], row[3], fr[1]);
            want.value = OUT_W'(blend(plane[0], plane[1], fr[2]));
            want.clamped = cl[0] | cl[1] | cl[2];
            if (c.known)
            begin
                want.value = c.known_value;
                want.clamped = c.known_clamped;
            end
            pending_samples.push_back(want);
            samples_sent++;
            if (want.clamped)
                clamped_sent++;
        end
    endtask

    // hold start low until every sample has returned and the block has settled
    task automatic drain_results();
        start <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result checker; results cannot be held off
    always @(posedge clk)
    begin
        sample_result_t want;
        if (rst_n && done === 1'b1)
        begin
            results_checked++;
            if (pending_samples.size() == 0)
                report_mismatch($sformatf("result %0d clamped=%0b with no sample pending",
                                          sample_value, was_clamped));
            else
            begin
                want = pending_samples.pop_front();
                if (sample_value !== want.value)
                    report_mismatch($sformatf("sample_value %0d, expected %0d",
                                              sample_value, $signed(want.value)));
                if (was_clamped !== want.clamped)
                    report_mismatch($sformatf("was_clamped %b, expected %b",
                                              was_clamped, want.clamped));
            end
        end
        else if (rst_n && done !== 1'b0)
            report_mismatch("done is unknown");
    end

    // stimulus
    initial
    begin
        grid_cmd_t          opening_rows [OPENING_ROWS];
        grid_cmd_t          probe;
        logic  [SIZE_W-1:0] size_val;
        int                 phase_end;
        int                 roll;
        int                 cell_idx;
        int                 frac;
        int                 pos [3];
        int                 lo [3];
        int                 hi [3];
        longint             fr;
        bit                 cl;
        int                 cx;
        int                 cy;
        int                 cz;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset sizes: a filled cube at the origin, one voxel at the far
        // corner, extremes of the coordinates, clamping on both sides, tie fractions
        opening_rows = '{
            voxel_write(0, 0, 0, 32767),
            voxel_write(1, 0, 0, -32768),
            voxel_write(0, 1, 0, 1000),
            voxel_write(1, 1, 0, -1000),
            voxel_write(0, 0, 1, 0),
            voxel_write(1, 0, 1, -1),
            voxel_write(0, 1, 1, 12345),
            voxel_write(1, 1, 1, -12346),
            voxel_write(63, 63, 63, 5),
            voxel_write(63, 63, 63, -32768),
            sample_point(0, 0, 0, 1'b1, 32767, 1'b0),
            sample_point(-1, -1, -1, 1'b1, 32767, 1'b1),
            sample_point(-8388608, -8388608, -8388608, 1'b1, 32767, 1'b1),
            sample_point(8388607, 8388607, 8388607, 1'b1, -32768, 1'b1),
            sample_point(63 * UNIT, 63 * UNIT, 63 * UNIT, 1'b1, -32768, 1'b0),
            sample_point(UNIT / 2, 0, 0, 1'b0, 0, 1'b0),
            sample_point(UNIT - 1, UNIT - 1, UNIT - 1, 1'b0, 0, 1'b0),
            sample_point(UNIT / 2, UNIT / 2, UNIT / 2, 1'b0, 0, 1'b0),
            sample_point(-5, UNIT / 2, UNIT - 1, 1'b0, 0, 1'b0)
        };
        foreach (opening_rows[i])
            issue_item(opening_rows[i]);

        // random part over several grid size settings
        for (int p = 0; p < SIZE_SETTINGS; p++)
        begin
            drain_results();
            for (int a = 0; a < 3; a++)
            begin
                if (p < FIXED_SIZES)
                    size_val = SIZE_W'(fixed_sizes[p][a]);
                else if ($urandom_range(0, 1))
                    size_val = SIZE_W'($urandom_range(2, 12));
                else
                    size_val = SIZE_W'($urandom);
                cfg_write <= 1'b1;
                cfg_index <= SIZE_REGS[a];
                cfg_data  <= size_val;
                // sizes outside the legal range saturate
                if (int'(size_val) < 2)
                    grid_dim[a] = 2;
                else if (int'(size_val) > AXIS_MAX_DEF)
                    grid_dim[a] = AXIS_MAX_DEF;
                else
                    grid_dim[a] = int'(size_val);
                focus_cell[a] = $urandom_range(0, grid_dim[a] - 1);
                @(posedge clk);
            end
            cfg_write <= 1'b0;
            size_settings_run++;

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 49) == 0)
                    steady_run = !steady_run;
                if ($urandom_range(0, 29) == 0)
                    for (int a = 0; a < 3; a++)
                        focus_cell[a] = $urandom_range(0, grid_dim[a] - 1);

                if ($urandom_range(0, 99) < 30)
                begin
                    // stray write: near the focus cell or anywhere in the store
                    for (int a = 0; a < 3; a++)
                    begin
                        if ($urandom_range(0, 1))
                        begin
                            pos[a] = focus_cell[a] + $urandom_range(0, 2);
                            if (pos[a] > AXIS_MAX_DEF - 1)
                                pos[a] = AXIS_MAX_DEF - 1;
                        end
                        else
                            pos[a] = $urandom_range(0, AXIS_MAX_DEF - 1);
                    end
                    issue_item(voxel_write(pos[0], pos[1], pos[2], pick_value()));
                end
                else
                begin
                    // sample point: mostly near the focus cell, some on edges or outside
                    for (int a = 0; a < 3; a++)
                    begin
                        cell_idx = focus_cell[a] + $urandom_range(0, 2);
                        if (cell_idx > grid_dim[a] - 1)
                            cell_idx = grid_dim[a] - 1;
                        case ($urandom_range(0, 9))
                            0: frac = 0;
                            1: frac = UNIT / 2;
                            2: frac = UNIT - 1;
                            default: frac = $urandom_range(0, UNIT - 1);
                        endcase
                        roll = $urandom_range(0, 99);
                        if (roll < 60)
                            pos[a] = cell_idx * UNIT + frac;
                        else if (roll < 70)
                            pos[a] = $urandom_range(0, grid_dim[a] - 1) * UNIT;
                        else if (roll < 77)
                            pos[a] = (grid_dim[a] - 1) * UNIT;
                        else if (roll < 85)
                            pos[a] = -$urandom_range(1, 40000);
                        else if (roll < 92)
                            pos[a] = (grid_dim[a] - 1) * UNIT + $urandom_range(1, 60000);
                        else
                            pos[a] = int'($urandom);
                    end
                    probe = sample_point(pos[0], pos[1], pos[2], 1'b0, 0, 1'b0);

                    // write any corner not yet written, then sample
                    for (int a = 0; a < 3; a++)
                        split_axis(probe.coord[a], grid_dim[a], lo[a], hi[a], fr, cl);
                    for (int k = 0; k < 8; k++)
                    begin
                        cx = k[0] ? hi[0] : lo[0];
                        cy = k[1] ? hi[1] : lo[1];
                        cz = k[2] ? hi[2] : lo[2];
                        if (!voxel_shadow.exists(voxel_key(cx, cy, cz)))
                            issue_item(voxel_write(cx, cy, cz, pick_value()));
                    end
                    issue_item(probe);
                end
            end
        end

        drain_results();
        $display("run covered %0d items: %0d voxel writes, %0d samples (%0d clamped)",
                 items_sent, writes_sent, samples_sent, clamped_sent);
        $display("%0d grid size settings, %0d results checked, %0d mismatches",
                 size_settings_run, results_checked, error_count);
        if (error_count == 0 && pending_samples.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial
    begin
        #6ms;
        $display("timeout: items or results stalled");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
